// File: rtl/core/sorted_list_insert_delete_assert.svh
// Assertion macros for the sorted list block.
// Used by the top level only; needs a clock and an active-low reset in scope.
`ifndef SORTED_LIST_INSERT_DELETE_ASSERT_SVH
`define SORTED_LIST_INSERT_DELETE_ASSERT_SVH

// same-cycle implication
`define SLI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted list check failed");

// next-cycle implication
`define SLI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted list check failed");

`endif

// File: rtl/core/sli_pkg.sv
// Shared types for the sorted list block: status and operation codes,
// and the control word broadcast to every cell. No dependencies.
package sli_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_DELETE = 1'b1
    } func_t;

    typedef struct packed {
        logic                     ins_en;
        logic                     del_en;
        logic                     found;
        logic signed [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

// File: rtl/core/sli_cell.sv
// One slot of the sorted chain: holds one entry, compares it to the
// broadcast value and shifts with its neighbors. Depends on sli_pkg.
module sli_cell
    import sli_pkg::*;
(
    input  logic                     clk,
    input  cell_ctrl_t               ctrl,
    input  logic                     occ,
    input  logic                     prev_keep,
    input  logic signed [DATA_W-1:0] prev_val,
    input  logic signed [DATA_W-1:0] next_val,
    output logic                     keep,
    output logic                     match,
    output logic signed [DATA_W-1:0] val
);

    logic signed [DATA_W-1:0] val_reg;
    logic signed [DATA_W-1:0] val_next;
    logic                     lt;

    assign lt    = val_reg < ctrl.value;
    assign keep  = occ && lt;
    assign match = occ && (val_reg == ctrl.value);
    assign val   = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (ctrl.ins_en && !keep)
        begin
            // first non-keeping cell takes the new value, the rest move right
            val_next = prev_keep ? ctrl.value : prev_val;
        end
        else if (ctrl.del_en && ctrl.found && occ && !lt)
        begin
            // from the first match on, everything moves left
            val_next = next_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

// File: rtl/core/sorted_list_insert_delete.sv
// Sorted list of signed 32-bit values held in a chain of CAPACITY cells.
// The chain and the entry count update when an input is accepted; the head,
// tail, count and status result is registered once the output is free, and
// no new input is accepted until that result has moved to the output.
// Reset clears the entry count and the handshake state; cell contents stay
// undefined and are never read unless written.
`include "sorted_list_insert_delete_assert.svh"

module sorted_list_insert_delete
    import sli_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     func,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               status,
    output logic [4:0]               entry_count,
    output logic signed [DATA_W-1:0] smallest_value,
    output logic signed [DATA_W-1:0] largest_value
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic                     in_fire;
    logic                     load_out;
    logic                     is_del;
    logic                     full;
    logic                     found;
    cell_ctrl_t               ctrl;

    logic [CAPACITY-1:0]      occ;
    logic [CAPACITY-1:0]      keep;
    logic [CAPACITY-1:0]      match;
    logic signed [DATA_W-1:0] cell_val [CAPACITY];
    logic signed [DATA_W-1:0] tail_val;
    logic signed [DATA_W-1:0] head_val;

    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic                     pend_reg;
    logic                     pend_next;
    status_t                  pend_status_reg;
    status_t                  pend_status_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    status_t                  status_reg;
    logic [4:0]               count_out_reg;
    logic signed [DATA_W-1:0] smallest_reg;
    logic signed [DATA_W-1:0] largest_reg;

    assign in_ready = !pend_reg;
    assign in_fire  = in_valid && in_ready;
    assign load_out = pend_reg && (!out_valid_reg || out_ready);
    assign is_del   = (func_t'(func) == FUNC_DELETE);
    assign full     = (count_reg >= CW'(CAPACITY));
    assign found    = |match;

    assign ctrl.ins_en = in_fire && !is_del && !full;
    assign ctrl.del_en = in_fire && is_del;
    assign ctrl.found  = found;
    assign ctrl.value  = value;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic                     pk;
            logic signed [DATA_W-1:0] pv;
            logic signed [DATA_W-1:0] nv;

            assign occ[gi] = (CW'(gi) < count_reg);

            if (gi == 0)
            begin : g_head
                assign pk = 1'b1;
                assign pv = cell_val[gi];
            end
            else
            begin : g_mid
                assign pk = keep[gi-1];
                assign pv = cell_val[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign nv = cell_val[gi];
            end
            else
            begin : g_next
                assign nv = cell_val[gi+1];
            end

            sli_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .occ       (occ[gi]),
                .prev_keep (pk),
                .prev_val  (pv),
                .next_val  (nv),
                .keep      (keep[gi]),
                .match     (match[gi]),
                .val       (cell_val[gi])
            );
        end
    endgenerate

    // tail entry: one-hot select on the last occupied cell
    always_comb
    begin
        tail_val = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (count_reg == CW'(i + 1))
            begin
                tail_val = tail_val | cell_val[i];
            end
        end
    end

    assign head_val = occ[0] ? cell_val[0] : '0;

    always_comb
    begin
        count_next       = count_reg;
        pend_next        = pend_reg;
        pend_status_next = pend_status_reg;
        if (in_fire)
        begin
            pend_next = 1'b1;
            if (!is_del)
            begin
                if (full)
                begin
                    pend_status_next = ST_FULL;
                end
                else
                begin
                    pend_status_next = ST_OK;
                    count_next       = count_reg + 1'b1;
                end
            end
            else if (count_reg == '0)
            begin
                pend_status_next = ST_EMPTY;
            end
            else if (!found)
            begin
                pend_status_next = ST_NOT_FOUND;
            end
            else
            begin
                pend_status_next = ST_OK;
                count_next       = count_reg - 1'b1;
            end
        end
        else if (load_out)
        begin
            pend_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_status_reg <= pend_status_next;
        if (load_out)
        begin
            status_reg    <= pend_status_reg;
            count_out_reg <= 5'(count_reg);
            smallest_reg  <= head_val;
            largest_reg   <= tail_val;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign entry_count    = count_out_reg;
    assign smallest_value = smallest_reg;
    assign largest_value  = largest_reg;

    `SLI_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(CAPACITY))
    `SLI_ASSERT_NEXT(a_insert_grows, clk, rst_n, ctrl.ins_en, count_reg == CW'($past(count_reg) + 1'b1))
    `SLI_ASSERT_NEXT(a_delete_miss_holds, clk, rst_n, ctrl.del_en && !found, count_reg == $past(count_reg))
    `SLI_ASSERT_NOW(a_result_ordered, clk, rst_n, out_valid_reg, smallest_reg <= largest_reg)

endmodule
